// ----- hdl/wgbs_pkg.sv -----
// package for the weight grid bilinear sampler: types, constants and helpers
`timescale 1ns / 1ps
package wgbs_pkg;

  localparam int unsigned MAX_GRID_X = 256;
  localparam int unsigned MAX_GRID_Z = 256;
  localparam int unsigned X_BITS     = $clog2(MAX_GRID_X);
  localparam int unsigned Z_BITS     = $clog2(MAX_GRID_Z);
  localparam int unsigned ADDR_W     = X_BITS + Z_BITS;
  localparam int unsigned DIM_W      = 9;
  localparam int unsigned SUM_W      = 18;
  localparam int unsigned NUM_W      = 33;

  localparam logic [15:0]      ONE_Q16  = 16'hFFFF;
  localparam logic [16:0]      FRAC_ONE = 17'h10000;
  localparam logic [DIM_W-1:0] DIM_MIN  = DIM_W'(2);
  localparam logic [DIM_W-1:0] DIM_RST  = DIM_W'(256);
  localparam logic [DIM_W-1:0] DIM_MAX_X = DIM_W'(MAX_GRID_X);
  localparam logic [DIM_W-1:0] DIM_MAX_Z = DIM_W'(MAX_GRID_Z);
  localparam logic [63:0]      CELL_RST = {ONE_Q16, 16'h0000, 16'h0000, 16'h0000};

  typedef enum logic [1:0] {
    FUNC_WRITE  = 2'd0,
    FUNC_READ   = 2'd1,
    FUNC_SAMPLE = 2'd2,
    FUNC_NONE   = 2'd3
  } func_e;

  typedef enum logic {
    REG_GRID_WIDTH = 1'b0,
    REG_GRID_DEPTH = 1'b1
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PREP,
    ST_FETCH,
    ST_READ,
    ST_LERP,
    ST_SUM,
    ST_DIVLD,
    ST_DIV,
    ST_WRITE,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [9:0]  cell_x;
    logic [9:0]  cell_z;
    logic [15:0] raw_w0;
    logic [15:0] raw_w1;
    logic [15:0] raw_w2;
    logic [15:0] raw_w3;
    logic [16:0] coord_u;
    logic [16:0] coord_v;
  } in_req_t;

  typedef struct packed {
    logic [15:0] out_w0;
    logic [15:0] out_w1;
    logic [15:0] out_w2;
    logic [15:0] out_w3;
  } out_res_t;

  // effective grid size: register clamped to [2, max]
  function automatic logic [DIM_W-1:0] eff_dim(logic [DIM_W-1:0] r, logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] e;
    if (r < DIM_MIN) e = DIM_MIN;
    else if (r > maxv) e = maxv;
    else e = r;
    return e;
  endfunction

  // a + (b - a) * t / 65536, rounded to nearest with halves up
  function automatic logic [15:0] lerp16(logic [15:0] a, logic [15:0] b, logic [15:0] t);
    logic signed [16:0] d;
    logic signed [33:0] p;
    logic signed [34:0] acc;
    logic [15:0]        r;
    d   = $signed({1'b0, b}) - $signed({1'b0, a});
    p   = d * $signed({1'b0, t});
    acc = $signed({3'b000, a, 16'h0000}) + 35'(p) + 35'sd32768;
    if (acc < 0) r = 16'h0000;
    else r = acc[31:16];
    return r;
  endfunction

endpackage

// ----- hdl/weight_grid_bilinear_sampler.sv -----
// top level of the weight grid bilinear sampler: sequencer, cell memory and divider
`timescale 1ns / 1ps
// One request at a time. After reset the block sweeps the whole cell memory to
// (0,0,0,1), one cell a cycle, before it takes its first request; register
// writes are taken during the sweep. The time a sample takes is set by the
// single read port of the cell memory (four neighbor reads in a row), the one
// shared lerp multiplier (twelve lerps) and the bit-serial divider, which works
// through the four channels one after another; a write passes the divider too.
// The result sits in an output register, so a new request is taken while the
// previous result still waits.
module weight_grid_bilinear_sampler (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [8:0]        cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  wgbs_pkg::in_req_t in_req_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output wgbs_pkg::out_res_t out_res_o
);
  import wgbs_pkg::*;

  state_e state_q, state_d;

  logic [DIM_W-1:0]  grid_w_q, grid_d_q;
  in_req_t           req_q;
  logic [X_BITS-1:0] x0_q, x1_q;
  logic [Z_BITS-1:0] z0_q, z1_q;
  logic [15:0]       tx_q, tz_q;
  logic [2:0]        k_q;
  logic [1:0]        ch_q, ph_q;
  logic [4:0]        cnt_q;
  logic [63:0]       cell_q [4];
  logic [15:0]       w_q [4];
  logic [15:0]       r0_q, r1_q;
  logic [SUM_W-1:0]  sum_q, rem_q;
  logic [15:0]       quo_q;
  logic [ADDR_W-1:0] clr_q;
  logic              out_valid_q;
  out_res_t          out_q;

  logic [63:0]       mem [2**ADDR_W];
  logic [63:0]       rd_q;
  logic              mem_re, mem_we;
  logic [ADDR_W-1:0] mem_raddr, mem_waddr;
  logic [63:0]       mem_wdata;

  logic [DIM_W-1:0]  eff_w, eff_d;
  logic [X_BITS-1:0] wm1;
  logic [Z_BITS-1:0] dm1;
  logic [X_BITS-1:0] cx;
  logic [Z_BITS-1:0] cz;
  logic [16:0]       uc, vc;
  logic [24:0]       fx, fz;
  logic [8:0]        fx_hi, fz_hi;
  logic [X_BITS-1:0] sx0;
  logic [Z_BITS-1:0] sz0;
  logic [15:0]       la, lb, lt, lres;
  logic [18:0]       trial;
  logic              ge;
  logic [NUM_W-1:0]  num;
  logic [SUM_W-1:0]  sum_c;
  logic              out_load;

  assign eff_w = eff_dim(grid_w_q, DIM_MAX_X);
  assign eff_d = eff_dim(grid_d_q, DIM_MAX_Z);
  assign wm1   = X_BITS'(eff_w - DIM_W'(1));
  assign dm1   = Z_BITS'(eff_d - DIM_W'(1));

  // cell coordinate clamp for read and write
  assign cx = (req_q.cell_x > 10'(wm1)) ? wm1 : req_q.cell_x[X_BITS-1:0];
  assign cz = (req_q.cell_z > 10'(dm1)) ? dm1 : req_q.cell_z[Z_BITS-1:0];

  // sample coordinate scaling
  assign uc    = (req_q.coord_u > FRAC_ONE) ? FRAC_ONE : req_q.coord_u;
  assign vc    = (req_q.coord_v > FRAC_ONE) ? FRAC_ONE : req_q.coord_v;
  assign fx    = uc * 25'(wm1);
  assign fz    = vc * 25'(dm1);
  assign fx_hi = fx[24:16];
  assign fz_hi = fz[24:16];
  assign sx0   = (fx_hi > 9'(wm1)) ? wm1 : fx_hi[X_BITS-1:0];
  assign sz0   = (fz_hi > 9'(dm1)) ? dm1 : fz_hi[Z_BITS-1:0];

  // shared lerp operands: row z0, row z1, then between the rows
  always_comb begin
    la = r0_q;
    lb = r1_q;
    lt = tz_q;
    unique case (ph_q)
      2'd0: begin
        la = cell_q[0][16*ch_q +: 16];
        lb = cell_q[1][16*ch_q +: 16];
        lt = tx_q;
      end
      2'd1: begin
        la = cell_q[2][16*ch_q +: 16];
        lb = cell_q[3][16*ch_q +: 16];
        lt = tx_q;
      end
      default: begin
        la = r0_q;
        lb = r1_q;
        lt = tz_q;
      end
    endcase
  end
  assign lres = lerp16(la, lb, lt);

  assign sum_c = SUM_W'(w_q[0]) + SUM_W'(w_q[1]) + SUM_W'(w_q[2]) + SUM_W'(w_q[3]);
  assign num   = NUM_W'({w_q[ch_q], 16'h0000}) - NUM_W'(w_q[ch_q]) + NUM_W'(sum_q >> 1);
  assign trial = {rem_q, quo_q[15]};
  assign ge    = trial >= {1'b0, sum_q};

  assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_q == '1) state_d = ST_IDLE;
      ST_IDLE:  if (in_valid_i) state_d = ST_PREP;
      ST_PREP: begin
        unique case (func_e'(req_q.func))
          FUNC_WRITE:  state_d = ST_SUM;
          FUNC_READ:   state_d = ST_READ;
          FUNC_SAMPLE: state_d = ST_FETCH;
          default:     state_d = ST_DONE;
        endcase
      end
      ST_FETCH: if (k_q == 3'd4) state_d = ST_LERP;
      ST_READ:  state_d = ST_DONE;
      ST_LERP:  if (ph_q == 2'd2 && ch_q == 2'd3) state_d = ST_SUM;
      ST_SUM: begin
        if (sum_c == '0) begin
          state_d = (func_e'(req_q.func) == FUNC_WRITE) ? ST_WRITE : ST_DONE;
        end else begin
          state_d = ST_DIVLD;
        end
      end
      ST_DIVLD: state_d = ST_DIV;
      ST_DIV: begin
        if (cnt_q == 5'd15) begin
          if (ch_q != 2'd3) state_d = ST_DIVLD;
          else if (func_e'(req_q.func) == FUNC_WRITE) state_d = ST_WRITE;
          else state_d = ST_DONE;
        end
      end
      ST_WRITE: state_d = ST_DONE;
      ST_DONE:  if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // memory and handshake controls
  always_comb begin
    in_ready_o = 1'b0;
    mem_re     = 1'b0;
    mem_we     = 1'b0;
    mem_raddr  = {cz, cx};
    mem_waddr  = {cz, cx};
    mem_wdata  = {w_q[3], w_q[2], w_q[1], w_q[0]};
    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = CELL_RST;
      end
      ST_IDLE: in_ready_o = 1'b1;
      ST_PREP: mem_re = (func_e'(req_q.func) == FUNC_READ);
      ST_FETCH: begin
        mem_re = (k_q < 3'd4);
        unique case (k_q[1:0])
          2'd0:    mem_raddr = {z0_q, x0_q};
          2'd1:    mem_raddr = {z0_q, x1_q};
          2'd2:    mem_raddr = {z1_q, x0_q};
          default: mem_raddr = {z1_q, x1_q};
        endcase
      end
      ST_WRITE: mem_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) rd_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      grid_w_q    <= DIM_RST;
      grid_d_q    <= DIM_RST;
      out_valid_q <= 1'b0;
      k_q         <= '0;
      ch_q        <= '0;
      ph_q        <= '0;
      cnt_q       <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + ADDR_W'(1);
      if (cfg_we_i) begin
        unique case (reg_idx_e'(cfg_idx_i))
          REG_GRID_WIDTH: grid_w_q <= cfg_data_i;
          default:        grid_d_q <= cfg_data_i;
        endcase
      end
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_PREP: begin
          k_q  <= '0;
          ch_q <= '0;
          ph_q <= '0;
        end
        ST_FETCH: k_q <= k_q + 3'd1;
        ST_LERP: begin
          if (ph_q == 2'd2) begin
            ph_q <= '0;
            ch_q <= ch_q + 2'd1;
          end else begin
            ph_q <= ph_q + 2'd1;
          end
        end
        ST_SUM:   ch_q <= '0;
        ST_DIVLD: cnt_q <= '0;
        ST_DIV: begin
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'd15) ch_q <= ch_q + 2'd1;
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      req_q <= in_req_i;
    end
    unique case (state_q)
      ST_PREP: begin
        x0_q   <= sx0;
        z0_q   <= sz0;
        x1_q   <= (sx0 == wm1) ? wm1 : sx0 + X_BITS'(1);
        z1_q   <= (sz0 == dm1) ? dm1 : sz0 + Z_BITS'(1);
        tx_q   <= fx[15:0];
        tz_q   <= fz[15:0];
        if (func_e'(req_q.func) == FUNC_NONE) begin
          w_q[0] <= '0;
          w_q[1] <= '0;
          w_q[2] <= '0;
          w_q[3] <= ONE_Q16;
        end else begin
          w_q[0] <= req_q.raw_w0;
          w_q[1] <= req_q.raw_w1;
          w_q[2] <= req_q.raw_w2;
          w_q[3] <= req_q.raw_w3;
        end
      end
      ST_FETCH: if (k_q != 3'd0) cell_q[k_q[1:0] - 2'd1] <= rd_q;
      ST_READ: begin
        w_q[0] <= rd_q[15:0];
        w_q[1] <= rd_q[31:16];
        w_q[2] <= rd_q[47:32];
        w_q[3] <= rd_q[63:48];
      end
      ST_LERP: begin
        unique case (ph_q)
          2'd0:    r0_q <= lres;
          2'd1:    r1_q <= lres;
          default: w_q[ch_q] <= lres;
        endcase
      end
      ST_SUM: begin
        sum_q <= sum_c;
        if (sum_c == '0) begin
          w_q[0] <= '0;
          w_q[1] <= '0;
          w_q[2] <= '0;
          w_q[3] <= ONE_Q16;
        end
      end
      ST_DIVLD: begin
        rem_q <= SUM_W'(num[NUM_W-1:16]);
        quo_q <= num[15:0];
      end
      ST_DIV: begin
        // restoring step: one quotient bit a cycle, numerator bits shift out the top
        rem_q <= ge ? SUM_W'(trial - {1'b0, sum_q}) : SUM_W'(trial);
        quo_q <= {quo_q[14:0], ge};
        if (cnt_q == 5'd15) w_q[ch_q] <= {quo_q[14:0], ge};
      end
      default: ;
    endcase
    if (out_load) begin
      out_q.out_w0 <= w_q[0];
      out_q.out_w1 <= w_q[1];
      out_q.out_w2 <= w_q[2];
      out_q.out_w3 <= w_q[3];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

`ifndef SYNTH
  // remainder stays below the divisor through the serial division
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < sum_q))
    else $error("divider remainder not below divisor");

  // a finished result always shows up on the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_o)
    else $error("result lost at output register");

  // no request taken while the memory sweep runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !in_ready_o && !mem_re)
    else $error("access during clearing pass");

  // lerp phase never leaves its three steps
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LERP) |-> (ph_q != 2'd3))
    else $error("bad lerp phase");
`endif

endmodule
